/* src/aabb_pkg.sv */
// shared types and constants for the aabb minimum overlap resolver
package aabb_pkg;

    localparam int CTR_W   = 24;  // signed Q15.8 center and push
    localparam int SIZE_W  = 16;  // unsigned Q8.8 box size
    localparam int SCALE_W = 12;  // unsigned Q4.8 scale
    localparam int HALF_W  = SIZE_W + SCALE_W;   // half extent in 2^-17 units
    localparam int BND_W   = 35;  // signed bound in 2^-17 units
    localparam int DIFF_W  = BND_W + 1;
    localparam int GAP_W   = BND_W;
    localparam int FRAC_SH = 9;   // 2^-17 units down to Q15.8
    localparam int MAG_W   = DIFF_W - FRAC_SH;
    localparam int IDX_W   = 3;

    localparam logic [1:0] CFG_OWN_DEPTH  = 2'd0;
    localparam logic [1:0] CFG_OWN_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_OWN_HEIGHT = 2'd2;

    typedef enum logic [2:0] {
        SIDE_NONE   = 3'd0,
        SIDE_BACK   = 3'd1,
        SIDE_FRONT  = 3'd2,
        SIDE_LEFT   = 3'd3,
        SIDE_RIGHT  = 3'd4,
        SIDE_BOTTOM = 3'd5,
        SIDE_TOP    = 3'd6
    } side_t;

    typedef struct packed {
        logic [2:0][CTR_W-1:0]  own_center;
        logic [SCALE_W-1:0]     own_scale;
        logic [2:0][CTR_W-1:0]  other_center;
        logic [2:0][SIZE_W-1:0] other_size;
        logic [SCALE_W-1:0]     other_scale;
    } query_t;

endpackage

/* src/aabb_min_overlap_resolver_core.sv */
// aabb minimum overlap resolver: input register, overlap and min-gap logic, result register
// a result passes the query register and then the result register before it is offered
// throughput: one query per cycle; the two registers pass through while out_stall is low
// all work sits between the query register and the result register in one pass
// reset clears both valid flags and sets own_depth, own_width, own_height to zero
module aabb_min_overlap_resolver_core
    import aabb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [SIZE_W-1:0]         cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [CTR_W-1:0]   own_center_x,
    input  logic signed [CTR_W-1:0]   own_center_y,
    input  logic signed [CTR_W-1:0]   own_center_z,
    input  logic [SCALE_W-1:0]        own_scale,
    input  logic signed [CTR_W-1:0]   other_center_x,
    input  logic signed [CTR_W-1:0]   other_center_y,
    input  logic signed [CTR_W-1:0]   other_center_z,
    input  logic [SIZE_W-1:0]         other_depth,
    input  logic [SIZE_W-1:0]         other_width,
    input  logic [SIZE_W-1:0]         other_height,
    input  logic [SCALE_W-1:0]        other_scale,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                hit_side,
    output logic signed [CTR_W-1:0]   push_x,
    output logic signed [CTR_W-1:0]   push_y,
    output logic signed [CTR_W-1:0]   push_z
);

    localparam logic [MAG_W-1:0] POS_MAX = MAG_W'((1 << (CTR_W - 1)) - 1);
    localparam logic [MAG_W-1:0] NEG_MAG = MAG_W'(1 << (CTR_W - 1));

    logic [SIZE_W-1:0] own_size_reg [3];
    logic              q_valid_reg;
    query_t            q_reg;
    logic              out_valid_reg;
    side_t             side_reg;
    logic [2:0][CTR_W-1:0] push_reg;

    logic              out_ready;
    logic              q_load;
    query_t            q_next;

    logic signed [BND_W-1:0] a_lo [3];
    logic signed [BND_W-1:0] a_hi [3];
    logic signed [BND_W-1:0] b_lo [3];
    logic signed [BND_W-1:0] b_hi [3];
    logic [HALF_W-1:0]       a_half [3];
    logic [HALF_W-1:0]       b_half [3];
    logic [GAP_W-1:0]        gap [6];
    logic signed [DIFF_W-1:0] diff [6];
    logic                    apart;

    logic [GAP_W-1:0]        pair_gap [3];
    logic [IDX_W-1:0]        pair_idx [3];
    logic [GAP_W-1:0]        best_gap;
    logic [IDX_W-1:0]        best_idx;
    logic [DIFF_W-1:0]       rounded;
    logic [MAG_W-1:0]        mag;
    logic [CTR_W-1:0]        push_val;
    side_t                   side_next;
    logic [2:0][CTR_W-1:0]   push_next;

    assign out_ready = !out_valid_reg || !out_stall;
    assign in_stall  = q_valid_reg && !out_ready;
    assign q_load    = in_valid && !in_stall;

    always_comb
    begin
        q_next.own_center[0]   = own_center_x;
        q_next.own_center[1]   = own_center_y;
        q_next.own_center[2]   = own_center_z;
        q_next.own_scale       = own_scale;
        q_next.other_center[0] = other_center_x;
        q_next.other_center[1] = other_center_y;
        q_next.other_center[2] = other_center_z;
        q_next.other_size[0]   = other_depth;
        q_next.other_size[1]   = other_width;
        q_next.other_size[2]   = other_height;
        q_next.other_scale     = other_scale;
    end

    // bounds held exactly in 2^-17 units: center * 512 and size * scale
    always_comb
    begin
        apart = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            a_half[i] = q_reg.own_scale * own_size_reg[i];
            b_half[i] = q_reg.other_scale * q_reg.other_size[i];
            a_lo[i] = $signed({{(BND_W-CTR_W-FRAC_SH){q_reg.own_center[i][CTR_W-1]}},
                               q_reg.own_center[i], {FRAC_SH{1'b0}}})
                      - $signed({{(BND_W-HALF_W){1'b0}}, a_half[i]});
            a_hi[i] = $signed({{(BND_W-CTR_W-FRAC_SH){q_reg.own_center[i][CTR_W-1]}},
                               q_reg.own_center[i], {FRAC_SH{1'b0}}})
                      + $signed({{(BND_W-HALF_W){1'b0}}, a_half[i]});
            b_lo[i] = $signed({{(BND_W-CTR_W-FRAC_SH){q_reg.other_center[i][CTR_W-1]}},
                               q_reg.other_center[i], {FRAC_SH{1'b0}}})
                      - $signed({{(BND_W-HALF_W){1'b0}}, b_half[i]});
            b_hi[i] = $signed({{(BND_W-CTR_W-FRAC_SH){q_reg.other_center[i][CTR_W-1]}},
                               q_reg.other_center[i], {FRAC_SH{1'b0}}})
                      + $signed({{(BND_W-HALF_W){1'b0}}, b_half[i]});
            if ((a_hi[i] < b_lo[i]) || (b_hi[i] < a_lo[i]))
                apart = 1'b1;
            diff[2*i]   = DIFF_W'(a_hi[i]) - DIFF_W'(b_lo[i]);
            diff[2*i+1] = DIFF_W'(a_lo[i]) - DIFF_W'(b_hi[i]);
        end
        for (int k = 0; k < 6; k++)
        begin
            gap[k] = diff[k][DIFF_W-1] ? GAP_W'(-diff[k]) : GAP_W'(diff[k]);
        end
    end

    // min tree; a later side only wins when strictly smaller
    always_comb
    begin
        for (int p = 0; p < 3; p++)
        begin
            if (gap[2*p+1] < gap[2*p])
            begin
                pair_gap[p] = gap[2*p+1];
                pair_idx[p] = IDX_W'(2*p+1);
            end
            else
            begin
                pair_gap[p] = gap[2*p];
                pair_idx[p] = IDX_W'(2*p);
            end
        end
        best_gap = pair_gap[0];
        best_idx = pair_idx[0];
        for (int p = 1; p < 3; p++)
        begin
            if (pair_gap[p] < best_gap)
            begin
                best_gap = pair_gap[p];
                best_idx = pair_idx[p];
            end
        end
    end

    // round half up to Q15.8 and saturate by push direction
    always_comb
    begin
        rounded = {1'b0, best_gap} + DIFF_W'(1 << (FRAC_SH - 1));
        mag     = rounded[DIFF_W-1:FRAC_SH];
        if (!best_idx[0])
        begin
            if (mag > NEG_MAG)
                push_val = NEG_MAG[CTR_W-1:0];
            else
                push_val = (~mag[CTR_W-1:0]) + CTR_W'(1);
        end
        else
        begin
            if (mag > POS_MAX)
                push_val = POS_MAX[CTR_W-1:0];
            else
                push_val = mag[CTR_W-1:0];
        end
        push_next = '0;
        if (apart)
        begin
            side_next = SIDE_NONE;
        end
        else
        begin
            side_next = side_t'(best_idx + IDX_W'(1));
            push_next[best_idx[2:1]] = push_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_size_reg[0] <= '0;
            own_size_reg[1] <= '0;
            own_size_reg[2] <= '0;
            q_valid_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_OWN_DEPTH:  own_size_reg[0] <= cfg_data;
                    CFG_OWN_WIDTH:  own_size_reg[1] <= cfg_data;
                    CFG_OWN_HEIGHT: own_size_reg[2] <= cfg_data;
                    default:        ;
                endcase
            end
            if (!in_stall)
                q_valid_reg <= in_valid;
            if (out_ready)
                out_valid_reg <= q_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_load)
            q_reg <= q_next;
        if (out_ready && q_valid_reg)
        begin
            side_reg <= side_next;
            push_reg <= push_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit_side  = side_reg;
    assign push_x    = push_reg[0];
    assign push_y    = push_reg[1];
    assign push_z    = push_reg[2];

endmodule

/* src/aabb_checker.sv */
// port-level checks for the aabb minimum overlap resolver, bound to the core
module aabb_checker
    import aabb_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cfg_we,
    input logic [1:0]                cfg_index,
    input logic [SIZE_W-1:0]         cfg_data,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic signed [CTR_W-1:0]   own_center_x,
    input logic signed [CTR_W-1:0]   own_center_y,
    input logic signed [CTR_W-1:0]   own_center_z,
    input logic [SCALE_W-1:0]        own_scale,
    input logic signed [CTR_W-1:0]   other_center_x,
    input logic signed [CTR_W-1:0]   other_center_y,
    input logic signed [CTR_W-1:0]   other_center_z,
    input logic [SIZE_W-1:0]         other_depth,
    input logic [SIZE_W-1:0]         other_width,
    input logic [SIZE_W-1:0]         other_height,
    input logic [SCALE_W-1:0]        other_scale,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [2:0]                hit_side,
    input logic signed [CTR_W-1:0]   push_x,
    input logic signed [CTR_W-1:0]   push_y,
    input logic signed [CTR_W-1:0]   push_z
);

    // a stalled result holds until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit_side)
            && $stable(push_x) && $stable(push_y) && $stable(push_z))
        else $error("result changed while stalled");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit_side == SIDE_NONE |-> push_x == '0 && push_y == '0 && push_z == '0)
        else $error("no overlap but nonzero push");

    // on an x side, only the push_x field may be nonzero
    a_single_axis: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (hit_side == SIDE_BACK || hit_side == SIDE_FRONT)
            |-> push_y == '0 && push_z == '0)
        else $error("x side pushes off axis");

    a_neg_side: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (hit_side == SIDE_LEFT || hit_side == SIDE_BOTTOM)
            |-> push_x == '0 && (push_y[CTR_W-1] || push_y == '0)
                && (push_z[CTR_W-1] || push_z == '0))
        else $error("negative side push has wrong sign or axis");

endmodule

bind aabb_min_overlap_resolver_core aabb_checker u_aabb_checker (.*);

/* tb/tb_aabb_min_overlap_resolver_core.sv */
// self-checking testbench for the aabb minimum overlap resolver core
`timescale 1ns / 1ps

module tb_aabb_min_overlap_resolver_core;
    import aabb_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;   // no register behind this index
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 255;
    localparam int MAX_GAP = 10;
    localparam int LONG_HOLD = 80;
    localparam int DRAIN_CYCLES = 6;
    localparam int QUIET_LIMIT = 1000;

    typedef struct packed {
        side_t              side;
        logic [CTR_W-1:0]   px;
        logic [CTR_W-1:0]   py;
        logic [CTR_W-1:0]   pz;
    } resolve_t;

    typedef struct {
        query_t     q;
        bit         typed;
        resolve_t   want;
    } row_t;

    typedef enum int {
        GEN_NOISE,
        GEN_NEAR,
        GEN_TOUCH,
        GEN_TIE
    } gen_kind_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [SIZE_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [CTR_W-1:0] own_center_x;
    logic signed [CTR_W-1:0] own_center_y;
    logic signed [CTR_W-1:0] own_center_z;
    logic [SCALE_W-1:0] own_scale;
    logic signed [CTR_W-1:0] other_center_x;
    logic signed [CTR_W-1:0] other_center_y;
    logic signed [CTR_W-1:0] other_center_z;
    logic [SIZE_W-1:0] other_depth;
    logic [SIZE_W-1:0] other_width;
    logic [SIZE_W-1:0] other_height;
    logic [SCALE_W-1:0] other_scale;
    logic out_valid;
    logic out_stall;
    logic [2:0] hit_side;
    logic signed [CTR_W-1:0] push_x;
    logic signed [CTR_W-1:0] push_y;
    logic signed [CTR_W-1:0] push_z;

    logic [SIZE_W-1:0] own_size [3];
    resolve_t pending_resolves [$];
    row_t dir_rows [$];
    int mismatches = 0;
    int quiet_cycles = 0;
    bit in_burst = 1'b0;
    bit out_burst = 1'b0;
    bit hold_request = 1'b0;

    aabb_min_overlap_resolver_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .own_center_x   (own_center_x),
        .own_center_y   (own_center_y),
        .own_center_z   (own_center_z),
        .own_scale      (own_scale),
        .other_center_x (other_center_x),
        .other_center_y (other_center_y),
        .other_center_z (other_center_z),
        .other_depth    (other_depth),
        .other_width    (other_width),
        .other_height   (other_height),
        .other_scale    (other_scale),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit_side       (hit_side),
        .push_x         (push_x),
        .push_y         (push_y),
        .push_z         (push_z)
    );

    always #5 clk = ~clk;

    // bounds kept exact in 2^-17 units: center * 512, half extent = size * scale
    function automatic resolve_t resolve_pair(input query_t q);
        longint lo_a[3];
        longint hi_a[3];
        longint lo_b[3];
        longint hi_b[3];
        longint gap[6];
        longint ctr_a, ctr_b, half_a, half_b, best, mag;
        int i, pick;
        bit apart;
        resolve_t r;
        r.side = SIDE_NONE;
        r.px = '0;
        r.py = '0;
        r.pz = '0;
        apart = 1'b0;
        for (i = 0; i < 3; i++)
        begin
            ctr_a = longint'($signed(q.own_center[i])) * 512;
            ctr_b = longint'($signed(q.other_center[i])) * 512;
            half_a = longint'(own_size[i]) * longint'(q.own_scale);
            half_b = longint'(q.other_size[i]) * longint'(q.other_scale);
            lo_a[i] = ctr_a - half_a;
            hi_a[i] = ctr_a + half_a;
            lo_b[i] = ctr_b - half_b;
            hi_b[i] = ctr_b + half_b;
            // touching faces still count as overlap
            if (hi_a[i] < lo_b[i] || hi_b[i] < lo_a[i])
                apart = 1'b1;
        end
        if (apart)
            return r;
        for (i = 0; i < 3; i++)
        begin
            gap[2*i] = hi_a[i] >= lo_b[i] ? hi_a[i] - lo_b[i] : lo_b[i] - hi_a[i];
            gap[2*i+1] = lo_a[i] >= hi_b[i] ? lo_a[i] - hi_b[i] : hi_b[i] - lo_a[i];
        end
        // strict less-than keeps the earlier side on a tie
        best = gap[0];
        pick = 0;
        for (i = 1; i < 6; i++)
        begin
            if (gap[i] < best)
            begin
                best = gap[i];
                pick = i;
            end
        end
        mag = (best + 256) >>> FRAC_SH;
        if (pick % 2 == 0)
        begin
            if (mag > 64'sd8388608)
                mag = 64'sd8388608;
            mag = -mag;
        end
        else if (mag > 64'sd8388607)
        begin
            mag = 64'sd8388607;
        end
        r.side = side_t'(pick + 1);
        case (pick / 2)
            0: r.px = CTR_W'(mag);
            1: r.py = CTR_W'(mag);
            default: r.pz = CTR_W'(mag);
        endcase
        return r;
    endfunction

    function automatic query_t pair_query(input int ox, input int oy, input int oz,
                                          input int osc, input int bx, input int by,
                                          input int bz, input int bd, input int bw,
                                          input int bh, input int bsc);
        query_t q;
        q.own_center[0] = CTR_W'(ox);
        q.own_center[1] = CTR_W'(oy);
        q.own_center[2] = CTR_W'(oz);
        q.own_scale = SCALE_W'(osc);
        q.other_center[0] = CTR_W'(bx);
        q.other_center[1] = CTR_W'(by);
        q.other_center[2] = CTR_W'(bz);
        q.other_size[0] = SIZE_W'(bd);
        q.other_size[1] = SIZE_W'(bw);
        q.other_size[2] = SIZE_W'(bh);
        q.other_scale = SCALE_W'(bsc);
        return q;
    endfunction

    // mostly overlapping pairs with random content, plus exact touches, ties and noise
    function automatic query_t make_query(input gen_kind_t kind);
        query_t q;
        int i, axis, lim, delta;
        longint c;
        for (i = 0; i < 3; i++)
        begin
            q.own_center[i] = CTR_W'($urandom);
            q.other_center[i] = CTR_W'($urandom);
            q.other_size[i] = SIZE_W'($urandom);
        end
        q.own_scale = SCALE_W'($urandom);
        q.other_scale = SCALE_W'($urandom);
        if (kind == GEN_NOISE)
            return q;
        if ($urandom_range(0, 1) == 1)
        begin
            for (i = 0; i < 3; i++)
                q.other_size[i] = SIZE_W'($urandom_range(0, 1023));
        end
        axis = 3;
        if (kind == GEN_TOUCH)
        begin
            // scale 2.0 on both boxes keeps the face distance on the Q15.8 grid
            q.own_scale = SCALE_W'(512);
            q.other_scale = SCALE_W'(512);
            axis = $urandom_range(0, 2);
        end
        for (i = 0; i < 3; i++)
        begin
            if (kind == GEN_TOUCH)
                lim = int'(own_size[i]) + int'(q.other_size[i]);
            else
                lim = (int'(own_size[i]) * int'(q.own_scale)
                       + int'(q.other_size[i]) * int'(q.other_scale)) / 512 + 2;
            if (kind == GEN_TIE)
            begin
                delta = 0;
            end
            else if (i == axis)
            begin
                delta = lim + int'($urandom_range(0, 1));
                if ($urandom_range(0, 1) == 1)
                    delta = -delta;
            end
            else
            begin
                delta = int'($urandom_range(0, 2 * lim)) - lim;
            end
            c = longint'($signed(q.own_center[i])) + delta;
            if (c > 64'sd8388607)
                c = 64'sd8388607;
            if (c < -64'sd8388608)
                c = -64'sd8388608;
            q.other_center[i] = c[CTR_W-1:0];
        end
        return q;
    endfunction

    task automatic add_row(input query_t q, input bit typed, input side_t s);
        row_t row;
        row.q = q;
        row.typed = typed;
        row.want.side = s;
        row.want.px = '0;
        row.want.py = '0;
        row.want.pz = '0;
        dir_rows.push_back(row);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [SIZE_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_OWN_DEPTH: own_size[0] = val;
            CFG_OWN_WIDTH: own_size[1] = val;
            CFG_OWN_HEIGHT: own_size[2] = val;
            default: ;
        endcase
    endtask

    // entered and left at a falling edge
    task automatic send_query(input query_t q, input resolve_t want);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        own_center_x <= q.own_center[0];
        own_center_y <= q.own_center[1];
        own_center_z <= q.own_center[2];
        own_scale <= q.own_scale;
        other_center_x <= q.other_center[0];
        other_center_y <= q.other_center[1];
        other_center_z <= q.other_center[2];
        other_depth <= q.other_size[0];
        other_width <= q.other_size[1];
        other_height <= q.other_size[2];
        other_scale <= q.other_scale;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_resolves.push_back(want);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_resolves.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic report_field(input string what, input longint want, input longint got);
        $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        mismatches++;
    endtask

    initial
    begin
        int k, phase, n, roll;
        gen_kind_t kind;
        query_t q;
        resolve_t want;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_OWN_DEPTH;
        cfg_data = '0;
        in_valid = 1'b0;
        own_center_x = '0;
        own_center_y = '0;
        own_center_z = '0;
        own_scale = '0;
        other_center_x = '0;
        other_center_y = '0;
        other_center_z = '0;
        other_depth = '0;
        other_width = '0;
        other_height = '0;
        other_scale = '0;
        for (k = 0; k < 3; k++)
            own_size[k] = '0;

        // own box is a point until the registers are written
        add_row(pair_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, SIDE_BACK);
        add_row(pair_query(0, 0, 0, 0, 8388607, 0, 0, 0, 0, 0, 0), 1'b1, SIDE_NONE);
        add_row(pair_query(-8388608, -8388608, -8388608, 4095, 8388607, 8388607, 8388607,
                           65535, 65535, 65535, 4095), 1'b1, SIDE_NONE);
        add_row(pair_query(8388607, 8388607, 8388607, 4095, -8388608, -8388608, -8388608,
                           65535, 65535, 65535, 4095), 1'b1, SIDE_NONE);
        add_row(pair_query(0, 0, 0, 4095, 64, 0, 0, 512, 512, 512, 256), 1'b0, SIDE_NONE);
        add_row(pair_query(0, 0, 0, 4095, -64, 0, 0, 512, 512, 512, 256), 1'b0, SIDE_NONE);
        add_row(pair_query(0, 0, 0, 4095, 0, 64, 0, 512, 512, 512, 256), 1'b0, SIDE_NONE);
        add_row(pair_query(0, 0, 0, 4095, 0, -64, 0, 512, 512, 512, 256), 1'b0, SIDE_NONE);
        add_row(pair_query(0, 0, 0, 4095, 0, 0, 64, 512, 512, 512, 256), 1'b0, SIDE_NONE);
        add_row(pair_query(0, 0, 0, 4095, 0, 0, -64, 512, 512, 512, 256), 1'b0, SIDE_NONE);
        add_row(pair_query(0, 0, 0, 4095, 0, 0, 0, 65535, 65535, 65535, 4095),
                1'b0, SIDE_NONE);
        // rounding right below and at the half step
        add_row(pair_query(0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 255), 1'b0, SIDE_NONE);
        add_row(pair_query(0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 256), 1'b0, SIDE_NONE);
        // faces exactly touching, then one step apart
        add_row(pair_query(0, 0, 0, 0, 256, 0, 0, 512, 512, 512, 256), 1'b1, SIDE_BACK);
        add_row(pair_query(0, 0, 0, 0, 257, 0, 0, 512, 512, 512, 256), 1'b1, SIDE_NONE);
        add_row(pair_query(-8388608, -8388608, -8388608, 4095, -8388608, -8388608, -8388608,
                           65535, 65535, 65535, 4095), 1'b0, SIDE_NONE);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < dir_rows.size(); k++)
        begin
            if (dir_rows[k].typed)
                want = dir_rows[k].want;
            else
                want = resolve_pair(dir_rows[k].q);
            send_query(dir_rows[k].q, want);
        end
        in_valid <= 1'b0;

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            write_reg(CFG_SPARE, SIZE_W'($urandom));
            case (phase)
                0:
                begin
                    write_reg(CFG_OWN_DEPTH, 16'hFFFF);
                    write_reg(CFG_OWN_WIDTH, 16'hFFFF);
                    write_reg(CFG_OWN_HEIGHT, 16'hFFFF);
                end
                2:
                begin
                    write_reg(CFG_OWN_DEPTH, 16'h0000);
                    write_reg(CFG_OWN_WIDTH, 16'h0000);
                    write_reg(CFG_OWN_HEIGHT, 16'h0000);
                end
                3:
                begin
                    write_reg(CFG_OWN_DEPTH, SIZE_W'($urandom_range(0, 1023)));
                    write_reg(CFG_OWN_WIDTH, SIZE_W'($urandom_range(0, 1023)));
                    write_reg(CFG_OWN_HEIGHT, SIZE_W'($urandom_range(0, 1023)));
                end
                4:
                begin
                    write_reg(CFG_OWN_DEPTH, 16'h0000);
                    write_reg(CFG_OWN_WIDTH, 16'hFFFF);
                    write_reg(CFG_OWN_HEIGHT, SIZE_W'($urandom));
                end
                default:
                begin
                    write_reg(CFG_OWN_DEPTH, SIZE_W'($urandom));
                    write_reg(CFG_OWN_WIDTH, SIZE_W'($urandom));
                    write_reg(CFG_OWN_HEIGHT, SIZE_W'($urandom));
                end
            endcase
            // let the result side sit still so the pipeline backs up into the input
            if (phase == 1)
                hold_request = 1'b1;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 39) == 0)
                    in_burst = !in_burst;
                roll = $urandom_range(0, 99);
                if (roll < 15)
                    kind = GEN_NOISE;
                else if (roll < 75)
                    kind = GEN_NEAR;
                else if (roll < 90)
                    kind = GEN_TOUCH;
                else
                    kind = GEN_TIE;
                q = make_query(kind);
                send_query(q, resolve_pair(q));
            end
            in_valid <= 1'b0;
        end

        wait_drained();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // result side: random stall before each transfer, one long hold on request
    initial
    begin
        int gap;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            if ($urandom_range(0, 39) == 0)
                out_burst = !out_burst;
            gap = out_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        resolve_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_resolves.size() == 0)
            begin
                $display("%0t: result with no query waiting: side %0d push %0d %0d %0d",
                         $time, hit_side, push_x, push_y, push_z);
                mismatches++;
            end
            else
            begin
                want = pending_resolves.pop_front();
                if (hit_side !== want.side)
                    report_field("hit_side", want.side, hit_side);
                if (push_x !== want.px)
                    report_field("push_x", $signed(want.px), push_x);
                if (push_y !== want.py)
                    report_field("push_y", $signed(want.py), push_y);
                if (push_z !== want.pz)
                    report_field("push_z", $signed(want.pz), push_z);
            end
        end
    end

    // count cycles without any transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

/* sim.f */
src/aabb_pkg.sv
src/aabb_min_overlap_resolver_core.sv
src/aabb_checker.sv
tb/tb_aabb_min_overlap_resolver_core.sv
